[sv/fst_pkg.sv]
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types, sizes and helpers for the maximum-frequency stack.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int SIZE_W     = $clog2(CAPACITY + 1);
  localparam int COUNT_W    = SIZE_W;
  localparam int ORDER_W    = 64;
  localparam int IO_W       = 32;
  localparam int OCC_W      = 7;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_INSERT,
    ST_UP_RD,
    ST_UP_CHK,
    ST_POP_TOP,
    ST_POP_LAST,
    ST_DN_L,
    ST_DN_LCHK,
    ST_DN_RCHK,
    ST_RESP
  } state_t;

  // One heap entry: value, count tag, push order tag
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_W-1:0]    count;
    logic [ORDER_W-1:0]    order;
  } entry_t;

  // Result request from the engine to the output register
  typedef struct packed {
    logic [IO_W-1:0]  popped;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } res_t;

  // Higher count wins; equal counts go to the later push
  function automatic logic ranks_above(input entry_t a, input entry_t b);
    if (a.count != b.count) return a.count > b.count;
    return a.order > b.order;
  endfunction

  // Sign-extend or truncate an input word into the stored value width
  function automatic logic [VALUE_BITS-1:0] to_val(input logic [IO_W-1:0] d);
    logic [VALUE_BITS-1:0] v;
    for (int k = 0; k < VALUE_BITS; k++) v[k] = (k < IO_W) ? d[k] : d[IO_W-1];
    return v;
  endfunction

  // Sign-extend or truncate a stored value into the output word
  function automatic logic [IO_W-1:0] from_val(input logic [VALUE_BITS-1:0] v);
    logic [IO_W-1:0] d;
    for (int k = 0; k < IO_W; k++) d[k] = (k < VALUE_BITS) ? v[k] : v[VALUE_BITS-1];
    return d;
  endfunction

endpackage

[sv/fst_ram.sv]
// ----------------------------------------------------------------------------
// fst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[sv/fst_engine.sv]
// ----------------------------------------------------------------------------
// fst_engine
// Sequencer for the heap: count scan, sift up on push, sift down on pop.
// ----------------------------------------------------------------------------
module fst_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic                   req_mode,
  input  logic [fst_pkg::IO_W-1:0] req_value,
  output logic                   res_valid,
  input  logic                   res_ready,
  output fst_pkg::res_t          res,
  output logic                   mem_we,
  output logic [fst_pkg::ADDR_W-1:0] mem_waddr,
  output fst_pkg::entry_t        mem_wdata,
  output logic [fst_pkg::ADDR_W-1:0] mem_raddr,
  input  fst_pkg::entry_t        mem_rdata
);
  import fst_pkg::*;

  localparam int CW = ADDR_W + 2;

  state_t                state_r, state_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [ORDER_W-1:0]    order_r, order_nxt;
  entry_t                ent_r, ent_nxt;
  entry_t                cand_r, cand_nxt;
  logic [ADDR_W-1:0]     cand_idx_r, cand_idx_nxt;
  logic                  cand_e_r, cand_e_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [SIZE_W-1:0]     scan_r, scan_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] popped_r, popped_nxt;
  status_t               status_r, status_nxt;

  logic                  accept;
  logic [CW-1:0]         lchild, rchild, size_w;
  logic [ADDR_W-1:0]     parent;
  logic                  left_wins, right_wins;
  entry_t                lbest;

  assign accept    = req_valid && req_ready;
  assign lchild    = {1'b0, idx_r, 1'b1};
  assign rchild    = lchild + CW'(1);
  assign size_w    = CW'(size_r);
  assign parent    = ADDR_W'((idx_r - ADDR_W'(1)) >> 1);
  assign left_wins = ranks_above(mem_rdata, ent_r);
  assign lbest     = left_wins ? mem_rdata : ent_r;
  assign right_wins = ranks_above(mem_rdata, cand_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!req_mode) begin
            if (size_r >= SIZE_W'(CAPACITY)) state_nxt = ST_RESP;
            else if (size_r == '0)           state_nxt = ST_INSERT;
            else                             state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = (size_r == '0) ? ST_RESP : ST_POP_TOP;
          end
        end
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: state_nxt = (scan_r + SIZE_W'(1) < size_r) ? ST_SCAN_RD : ST_INSERT;
      ST_INSERT:   state_nxt = ST_UP_RD;
      ST_UP_RD:    state_nxt = (idx_r == '0) ? ST_RESP : ST_UP_CHK;
      ST_UP_CHK:   state_nxt = ranks_above(ent_r, mem_rdata) ? ST_UP_RD : ST_RESP;
      ST_POP_TOP:  state_nxt = (size_r == SIZE_W'(1)) ? ST_RESP : ST_POP_LAST;
      ST_POP_LAST: state_nxt = ST_DN_L;
      ST_DN_L:     state_nxt = (lchild < size_w) ? ST_DN_LCHK : ST_RESP;
      ST_DN_LCHK: begin
        if (rchild < size_w) state_nxt = ST_DN_RCHK;
        else                 state_nxt = left_wins ? ST_DN_L : ST_RESP;
      end
      ST_DN_RCHK:  state_nxt = (right_wins || !cand_e_r) ? ST_DN_L : ST_RESP;
      ST_RESP:     state_nxt = res_ready ? ST_IDLE : ST_RESP;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = ent_r;
    mem_raddr = '0;
    req_ready = (state_r == ST_IDLE);
    res_valid = (state_r == ST_RESP);
    res.popped    = from_val(popped_r);
    res.status    = status_r;
    res.occupancy = OCC_W'(size_r);
    unique case (state_r)
      ST_SCAN_RD: mem_raddr = scan_r[ADDR_W-1:0];
      ST_UP_RD: begin
        mem_raddr = parent;
        mem_we    = (idx_r == '0);
      end
      ST_UP_CHK: begin
        mem_we = 1'b1;
        if (ranks_above(ent_r, mem_rdata)) mem_wdata = mem_rdata;
      end
      ST_POP_TOP: mem_raddr = ADDR_W'(size_r - SIZE_W'(1));
      ST_DN_L: begin
        mem_raddr = lchild[ADDR_W-1:0];
        mem_we    = !(lchild < size_w);
      end
      ST_DN_LCHK: begin
        mem_raddr = rchild[ADDR_W-1:0];
        if (!(rchild < size_w)) begin
          mem_we    = 1'b1;
          mem_wdata = lbest;
        end
      end
      ST_DN_RCHK: begin
        mem_we    = 1'b1;
        mem_wdata = right_wins ? mem_rdata : cand_r;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    size_nxt     = size_r;
    order_nxt    = order_r;
    ent_nxt      = ent_r;
    cand_nxt     = cand_r;
    cand_idx_nxt = cand_idx_r;
    cand_e_nxt   = cand_e_r;
    idx_nxt      = idx_r;
    scan_nxt     = scan_r;
    cnt_nxt      = cnt_r;
    popped_nxt   = popped_r;
    status_nxt   = status_r;
    case (state_r)
      ST_IDLE: begin
        ent_nxt.value = to_val(req_value);
        scan_nxt      = '0;
        cnt_nxt       = '0;
        popped_nxt    = '0;
        status_nxt    = STAT_OK;
        if (!req_mode && size_r >= SIZE_W'(CAPACITY)) status_nxt = STAT_FULL;
        if (req_mode && size_r == '0)                 status_nxt = STAT_EMPTY;
      end
      ST_SCAN_CHK: begin
        if (mem_rdata.value == ent_r.value) cnt_nxt = cnt_r + COUNT_W'(1);
        scan_nxt = scan_r + SIZE_W'(1);
      end
      ST_INSERT: begin
        ent_nxt.count = cnt_r + COUNT_W'(1);
        ent_nxt.order = order_r;
        order_nxt     = order_r + ORDER_W'(1);
        idx_nxt       = size_r[ADDR_W-1:0];
        size_nxt      = size_r + SIZE_W'(1);
      end
      ST_UP_CHK: if (ranks_above(ent_r, mem_rdata)) idx_nxt = parent;
      ST_POP_TOP: begin
        popped_nxt = mem_rdata.value;
        size_nxt   = size_r - SIZE_W'(1);
      end
      ST_POP_LAST: begin
        ent_nxt = mem_rdata;
        idx_nxt = '0;
      end
      ST_DN_LCHK: begin
        cand_nxt     = lbest;
        cand_e_nxt   = !left_wins;
        cand_idx_nxt = lchild[ADDR_W-1:0];
        if (!(rchild < size_w) && left_wins) idx_nxt = lchild[ADDR_W-1:0];
      end
      ST_DN_RCHK: begin
        if (right_wins)     idx_nxt = rchild[ADDR_W-1:0];
        else if (!cand_e_r) idx_nxt = cand_idx_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      size_r  <= '0;
      order_r <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      order_r <= order_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    cand_r     <= cand_nxt;
    cand_idx_r <= cand_idx_nxt;
    cand_e_r   <= cand_e_nxt;
    idx_r      <= idx_nxt;
    scan_r     <= scan_nxt;
    cnt_r      <= cnt_nxt;
    popped_r   <= popped_nxt;
    status_r   <= status_nxt;
  end

endmodule

[sv/frequency_stack.sv]
// ----------------------------------------------------------------------------
// frequency_stack
// Maximum-frequency stack: push values, pop the most frequent, latest first.
// ----------------------------------------------------------------------------
// Each request is a push (in_tuser = 0) or a pop (in_tuser = 1) and yields
// exactly one result. All entries live in one heap RAM with registered reads;
// the engine works on one request at a time, walking the RAM step by step.
// A push first counts matching values by reading every held entry (states
// SCAN_RD and SCAN_CHK for each), then sifts up (UP_RD and UP_CHK per level).
// A pop reads the top and last entries and sifts down (DN_L, DN_LCHK and, where
// a right child exists, DN_RCHK per level). Pops on an empty stack and pushes
// on a full one go straight to the result. A new request is taken while the
// last result still waits in the output register.
module frequency_stack (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic        in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // popped_value[31:0], occupancy[38:32], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);
  import fst_pkg::*;

  logic            res_valid, res_ready;
  res_t            res;
  logic            mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;
  logic            out_valid_r;
  res_t            out_r;

  assign mem_rdata = entry_t'(rdata_raw);

  fst_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata_raw)
  );

  fst_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_mode  (in_tuser),
    .req_value (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_ready) out_valid_r <= res_valid;
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.occupancy, out_r.popped};
  assign out_tuser  = out_r.status;

endmodule

[sv/fst_checker.sv]
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks for frequency_stack, bound to the top level.
// ----------------------------------------------------------------------------
module fst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import fst_pkg::*;

  // a pop on empty leaves nothing held and returns zero
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_EMPTY |-> out_tdata[38:0] == 39'd0)
    else $error("empty result with data or occupancy");

  // a dropped push only happens at full capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_FULL |->
      out_tdata[38:32] == OCC_W'(CAPACITY) && out_tdata[31:0] == 32'd0)
    else $error("full status below capacity");

  // occupancy never exceeds capacity
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[38:32] <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed under stall");

endmodule

bind frequency_stack fst_checker u_fst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
